/* design/bbt_pkg.sv */
// ----------------------------------------------------------------------------
// Bar/beat/tick converter package
// Shared widths, codes, item and result types for the converter blocks.
// ----------------------------------------------------------------------------
package bbt_pkg;

   localparam int MAX_SECTIONS_DEF = 8;

   localparam int OP_W       = 2;
   localparam int IDX_W      = 3;
   localparam int TICK_W     = 31;
   localparam int NUM_W      = 8;
   localparam int DEN_W      = 7;
   localparam int BAR_IN_W   = 24;
   localparam int BEAT_W     = 8;
   localparam int OFFS_IN_W  = 20;
   localparam int OFFS_OUT_W = 24;
   localparam int TPQ_W      = 16;
   localparam int SIU_W      = 4;
   localparam int TPB_W      = 18;
   localparam int TPBAR_W    = 26;
   localparam int BAR_ACC_W  = 32;
   localparam int PROD_W     = 50;
   localparam int START_W    = 51;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0]     TICK_MAX   = '1;
   localparam logic [TPQ_W-1:0]      TPQ_RESET  = 16'd480;
   localparam logic [SIU_W-1:0]      SIU_RESET  = 4'd1;
   localparam logic [NUM_W-1:0]      DEF_BEATS  = 8'd4;
   localparam logic [DEN_W-1:0]      DEF_NOTE   = 7'd4;
   localparam logic [CSR_IDX_W-1:0]  CSR_TPQ    = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_SIU    = 2'd1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_TO_BBT  = 2'd1,
      OP_TO_TICK = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                kind;
      logic [IDX_W-1:0]      idx;
      logic [TICK_W-1:0]     start;
      logic [NUM_W-1:0]      num;
      logic [DEN_W-1:0]      den;
      logic [TICK_W-1:0]     tick;
      logic [BAR_IN_W-1:0]   bar;
      logic [BEAT_W-1:0]     beat;
      logic [OFFS_IN_W-1:0]  offs;
   } cmd_type;

   typedef struct packed {
      logic [TICK_W-1:0] start;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } entry_type;

   typedef struct packed {
      logic [TICK_W-1:0]     tick;
      logic [TICK_W-1:0]     bar;
      logic [BEAT_W-1:0]     beat;
      logic [OFFS_OUT_W-1:0] offs;
      logic                  status;
   } result_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_RD_CUR,
      BK_RD_NXT,
      BK_DEN,
      BK_TPB,
      BK_BAR,
      BK_SPLIT,
      BK_WAIT_T,
      BK_WAIT_B,
      BK_WAIT_S,
      BK_MUL_ST,
      BK_ADD_ST,
      BK_FIND,
      BK_FIND_RD,
      BK_FIND_CMP,
      BK_FIND_DIV,
      BK_MUL_BT,
      BK_SUM,
      BK_OUT
   } back_state_type;

endpackage

/* design/bbt_front.sv */
// ----------------------------------------------------------------------------
// Converter front end
// Accepts items, decodes the operation, clamps the bar and queues them.
// ----------------------------------------------------------------------------
module bbt_front import bbt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic [TICK_W-1:0]     req_start_tick,
   input  logic [NUM_W-1:0]      req_sig_numerator,
   input  logic [DEN_W-1:0]      req_sig_denominator,
   input  logic [TICK_W-1:0]     req_tick_in,
   input  logic [BAR_IN_W-1:0]   req_bar_in,
   input  logic [BEAT_W-1:0]     req_beat_in,
   input  logic [OFFS_IN_W-1:0]  req_offset_in_beat,
   output logic                  q_valid,
   output cmd_type               q_cmd,
   input  logic                  q_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd;
   logic       push;
   logic       pop;

   always_comb begin
      cmd.kind  = op_type'(req_op);
      cmd.idx   = req_entry_index;
      cmd.start = req_start_tick;
      cmd.num   = req_sig_numerator;
      cmd.den   = req_sig_denominator;
      cmd.tick  = req_tick_in;
      cmd.bar   = (req_bar_in == '0) ? BAR_IN_W'(1) : req_bar_in;
      cmd.beat  = req_beat_in;
      cmd.offs  = req_offset_in_beat;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

/* design/bbt_div.sv */
// ----------------------------------------------------------------------------
// Converter divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbt_div import bbt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                div_start,
   input  logic [TICK_W-1:0]   div_dividend,
   input  logic [TPBAR_W-1:0]  div_divisor,
   output logic                div_busy,
   output logic                div_done,
   output logic [TICK_W-1:0]   div_quot,
   output logic [TPBAR_W-1:0]  div_rem
);

   logic [TPBAR_W-1:0] rem_ff, rem_in;
   logic [TICK_W-1:0]  quo_ff, quo_in;
   logic [TPBAR_W-1:0] dvs_ff, dvs_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [TPBAR_W:0]   trial;
   logic               ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[TICK_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_start) begin
         rem_in  = '0;
         quo_in  = div_dividend;
         dvs_in  = div_divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? TPBAR_W'(trial - {1'b0, dvs_ff}) : trial[TPBAR_W-1:0];
         quo_in = {quo_ff[TICK_W-2:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign div_busy = busy_ff;
   assign div_done = done_ff;
   assign div_quot = quo_ff;
   assign div_rem  = rem_ff;

endmodule

/* design/bbt_back.sv */
// ----------------------------------------------------------------------------
// Converter back end
// Holds the section table and walks it with a shared divider per item.
// ----------------------------------------------------------------------------
module bbt_back import bbt_pkg::*; #(
   parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   input  logic [TPQ_W-1:0]       tpq,
   input  logic [SIU_W-1:0]       siu,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [TICK_W-1:0]      rsp_tick_out,
   output logic [TICK_W-1:0]      rsp_bar_out,
   output logic [BEAT_W-1:0]      rsp_beat_out,
   output logic [OFFS_OUT_W-1:0]  rsp_offset_out,
   output logic                   rsp_status
);

   localparam int NW = $clog2(MAX_SECTIONS + 1);
   localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [NW-1:0]        i_ff, i_in;
   logic [BAR_ACC_W-1:0] bar_ff, bar_in;
   logic [TICK_W-1:0]    pos_ff, pos_in;
   logic [TICK_W-1:0]    nxt_ff, nxt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [TPB_W-1:0]     tpb_ff, tpb_in;
   logic [TPBAR_W-1:0]   tpbar_ff, tpbar_in;
   logic                 last_ff, last_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic signed [28:0]   pbt_ff, pbt_in;
   result_type           res_ff, res_in;
   result_type           rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   entry_type            sect_mem [MAX_SECTIONS];
   entry_type            rd_data_ff;
   logic                 rd_dflt_ff;
   logic                 w0_ff;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic                 mem_we;
   entry_type            rdata;
   entry_type            wentry;

   logic                 div_start;
   logic [TICK_W-1:0]    div_dividend;
   logic [TPBAR_W-1:0]   div_divisor;
   logic                 div_busy;
   logic                 div_done;
   logic [TICK_W-1:0]    div_quot;
   logic [TPBAR_W-1:0]   div_rem;

   logic [NW-1:0]        n_used;
   logic [TICK_W-1:0]    span_ticks;
   logic [TICK_W-1:0]    tdiff;
   logic [BAR_ACC_W:0]   bar_sum;
   logic                 out_free;
   logic signed [9:0]    beat_m1;
   logic signed [18:0]   tpb_s;
   logic signed [52:0]   sum_s;

   bbt_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_busy     (div_busy),
      .div_done     (div_done),
      .div_quot     (div_quot),
      .div_rem      (div_rem)
   );

   assign n_used = (int'(siu) > MAX_SECTIONS) ? NW'(MAX_SECTIONS) : NW'(siu);
   assign rdata  = rd_dflt_ff ? entry_type'{start: '0, num: DEF_BEATS, den: DEF_NOTE}
                              : rd_data_ff;
   assign wr_addr = AW'(q_cmd.idx);
   assign wentry  = '{start: q_cmd.start, num: q_cmd.num, den: q_cmd.den};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      i_in         = i_ff;
      bar_in       = bar_ff;
      pos_in       = pos_ff;
      nxt_in       = nxt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      tpb_in       = tpb_ff;
      tpbar_in     = tpbar_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      start_in     = start_ff;
      pbt_in       = pbt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      span_ticks   = (nxt_ff >= pos_ff) ? nxt_ff - pos_ff : '0;
      tdiff        = (cmd_ff.tick >= pos_ff) ? cmd_ff.tick - pos_ff : '0;
      bar_sum      = {1'b0, bar_ff} + (BAR_ACC_W + 1)'(div_quot);
      beat_m1      = $signed({2'b00, cmd_ff.beat}) - 10'sd1;
      tpb_s        = $signed({1'b0, tpb_ff});
      sum_s        = $signed({2'b00, start_ff}) + 53'(pbt_ff)
                     + $signed({33'b0, cmd_ff.offs});

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               i_in   = '0;
               bar_in = BAR_ACC_W'(1);
               pos_in = '0;
               res_in = '0;
               case (q_cmd.kind)
                  OP_LOAD: begin
                     mem_we   = (int'(q_cmd.idx) < MAX_SECTIONS);
                     state_in = BK_OUT;
                  end
                  OP_TO_BBT: begin
                     if (n_used == '0) begin
                        res_in.bar  = TICK_W'(1);
                        res_in.beat = BEAT_W'(1);
                        state_in    = BK_OUT;
                     end else begin
                        state_in = BK_RD_CUR;
                     end
                  end
                  OP_TO_TICK: begin
                     if (q_cmd.bar == BAR_IN_W'(1) || n_used == '0) begin
                        start_in = '0;
                        state_in = BK_FIND;
                     end else begin
                        state_in = BK_RD_CUR;
                     end
                  end
                  default: begin
                     state_in = BK_OUT;
                  end
               endcase
            end
         end
         BK_RD_CUR: begin
            rd_addr  = AW'(i_ff);
            state_in = BK_RD_NXT;
         end
         BK_RD_NXT: begin
            num_in  = rdata.num;
            den_in  = rdata.den;
            last_in = ((NW + 1)'(i_ff) + (NW + 1)'(1)) == (NW + 1)'(n_used);
            rd_addr = last_in ? AW'(i_ff) : AW'(i_ff + NW'(1));
            state_in = BK_DEN;
         end
         BK_DEN: begin
            nxt_in = rdata.start;
            if (den_ff == '0) begin
               res_in        = '0;
               res_in.status = 1'b1;
               state_in      = BK_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = TICK_W'({tpq, 2'b00});
               div_divisor  = TPBAR_W'(den_ff);
               state_in     = BK_TPB;
            end
         end
         BK_TPB: begin
            if (div_done) begin
               if (div_quot == '0) begin
                  res_in        = '0;
                  res_in.status = 1'b1;
                  state_in      = BK_OUT;
               end else begin
                  tpb_in   = div_quot[TPB_W-1:0];
                  state_in = BK_BAR;
               end
            end
         end
         BK_BAR: begin
            tpbar_in = tpb_ff * num_ff;
            state_in = BK_SPLIT;
         end
         BK_SPLIT: begin
            if (tpbar_ff == '0) begin
               res_in        = '0;
               res_in.status = 1'b1;
               state_in      = BK_OUT;
            end else if (cmd_ff.kind == OP_TO_BBT && (last_ff || cmd_ff.tick < nxt_ff)) begin
               div_start    = 1'b1;
               div_dividend = tdiff;
               div_divisor  = tpbar_ff;
               state_in     = BK_WAIT_T;
            end else if (cmd_ff.kind == OP_TO_TICK && last_ff) begin
               state_in = BK_MUL_ST;
            end else begin
               div_start    = 1'b1;
               div_dividend = span_ticks;
               div_divisor  = tpbar_ff;
               state_in     = BK_WAIT_S;
            end
         end
         BK_WAIT_T: begin
            if (div_done) begin
               bar_in       = bar_sum[BAR_ACC_W] ? '1 : bar_sum[BAR_ACC_W-1:0];
               div_start    = 1'b1;
               div_dividend = TICK_W'(div_rem);
               div_divisor  = TPBAR_W'(tpb_ff);
               state_in     = BK_WAIT_B;
            end
         end
         BK_WAIT_B: begin
            if (div_done) begin
               res_in.bar  = (bar_ff > BAR_ACC_W'(TICK_MAX)) ? TICK_MAX
                                                              : bar_ff[TICK_W-1:0];
               res_in.beat = div_quot[BEAT_W-1:0] + BEAT_W'(1);
               res_in.offs = OFFS_OUT_W'(div_rem);
               state_in    = BK_OUT;
            end
         end
         BK_WAIT_S: begin
            if (div_done) begin
               if (cmd_ff.kind == OP_TO_TICK
                   && bar_sum >= (BAR_ACC_W + 1)'(cmd_ff.bar)) begin
                  state_in = BK_MUL_ST;
               end else begin
                  bar_in   = bar_sum[BAR_ACC_W] ? '1 : bar_sum[BAR_ACC_W-1:0];
                  pos_in   = nxt_ff;
                  i_in     = i_ff + NW'(1);
                  state_in = BK_RD_CUR;
               end
            end
         end
         BK_MUL_ST: begin
            prod_in  = (cmd_ff.bar - bar_ff[BAR_IN_W-1:0]) * tpbar_ff;
            state_in = BK_ADD_ST;
         end
         BK_ADD_ST: begin
            start_in = START_W'(pos_ff) + START_W'(prod_ff);
            state_in = BK_FIND;
         end
         BK_FIND: begin
            i_in = n_used;
            if (n_used != '0) begin
               state_in = BK_FIND_RD;
            end else if (tpq == '0) begin
               res_in        = '0;
               res_in.status = 1'b1;
               state_in      = BK_OUT;
            end else begin
               tpb_in   = TPB_W'(tpq);
               state_in = BK_MUL_BT;
            end
         end
         BK_FIND_RD: begin
            rd_addr  = AW'(i_ff - NW'(1));
            state_in = BK_FIND_CMP;
         end
         BK_FIND_CMP: begin
            if (START_W'(rdata.start) <= start_ff) begin
               if (rdata.den == '0) begin
                  res_in        = '0;
                  res_in.status = 1'b1;
                  state_in      = BK_OUT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = TICK_W'({tpq, 2'b00});
                  div_divisor  = TPBAR_W'(rdata.den);
                  state_in     = BK_FIND_DIV;
               end
            end else begin
               i_in = i_ff - NW'(1);
               if (i_ff != NW'(1)) begin
                  state_in = BK_FIND_RD;
               end else if (tpq == '0) begin
                  res_in        = '0;
                  res_in.status = 1'b1;
                  state_in      = BK_OUT;
               end else begin
                  tpb_in   = TPB_W'(tpq);
                  state_in = BK_MUL_BT;
               end
            end
         end
         BK_FIND_DIV: begin
            if (div_done) begin
               if (div_quot == '0) begin
                  res_in        = '0;
                  res_in.status = 1'b1;
                  state_in      = BK_OUT;
               end else begin
                  tpb_in   = div_quot[TPB_W-1:0];
                  state_in = BK_MUL_BT;
               end
            end
         end
         BK_MUL_BT: begin
            pbt_in   = beat_m1 * tpb_s;
            state_in = BK_SUM;
         end
         BK_SUM: begin
            res_in = '0;
            if (sum_s < 53'sd0) begin
               res_in.tick = '0;
            end else if (sum_s > $signed({22'b0, TICK_MAX})) begin
               res_in.tick = TICK_MAX;
            end else begin
               res_in.tick = sum_s[TICK_W-1:0];
            end
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         w0_ff        <= 1'b0;
         rd_dflt_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we && wr_addr == '0) begin
            w0_ff <= 1'b1;
         end
         rd_dflt_ff   <= (rd_addr == '0) && !w0_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      i_ff     <= i_in;
      bar_ff   <= bar_in;
      pos_ff   <= pos_in;
      nxt_ff   <= nxt_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      tpb_ff   <= tpb_in;
      tpbar_ff <= tpbar_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      start_ff <= start_in;
      pbt_ff   <= pbt_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sect_mem[wr_addr] <= wentry;
      end
      rd_data_ff <= sect_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tick_out   = rsp_ff.tick;
   assign rsp_bar_out    = rsp_ff.bar;
   assign rsp_beat_out   = rsp_ff.beat;
   assign rsp_offset_out = rsp_ff.offs;
   assign rsp_status     = rsp_ff.status;

`ifndef NO_ASSERTIONS
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("Divider restarted while busy.");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_valid && state_ff == BK_IDLE))
      else $error("Queue popped without an item.");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == BK_OUT)
      else $error("Result left the back end while the output was full.");
`endif

endmodule

/* design/bar_beat_tick_converter.sv */
// ----------------------------------------------------------------------------
// Bar/beat/tick converter
// Converts between absolute ticks and bar/beat/tick over a section table.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Contents
// req_      in         valid / stall      op, table entry, tick, bar/beat/offset
// rsp_      out        valid / stall      tick, bar, beat, offset, status
// csr_      in         valid / ready      register index and write data
//
// A conversion walks the section table one section at a time, dividing on the
// one-bit-per-cycle divider; the back end finishes each item before it takes the next.
// Reset is synchronous and active high and restores the default 4/4 section.
// A two-item queue keeps req_ open while the back end works or rsp_ is stalled, until it fills.
// ----------------------------------------------------------------------------
module bar_beat_tick_converter import bbt_pkg::*; #(
   parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [IDX_W-1:0]       req_entry_index,
   input  logic [TICK_W-1:0]      req_start_tick,
   input  logic [NUM_W-1:0]       req_sig_numerator,
   input  logic [DEN_W-1:0]       req_sig_denominator,
   input  logic [TICK_W-1:0]      req_tick_in,
   input  logic [BAR_IN_W-1:0]    req_bar_in,
   input  logic [BEAT_W-1:0]      req_beat_in,
   input  logic [OFFS_IN_W-1:0]   req_offset_in_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [TICK_W-1:0]      rsp_tick_out,
   output logic [TICK_W-1:0]      rsp_bar_out,
   output logic [BEAT_W-1:0]      rsp_beat_out,
   output logic [OFFS_OUT_W-1:0]  rsp_offset_out,
   output logic                   rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [TPQ_W-1:0] tpq_ff, tpq_in;
   logic [SIU_W-1:0] siu_ff, siu_in;
   logic             q_valid;
   cmd_type          q_cmd;
   logic             q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      tpq_in = tpq_ff;
      siu_in = siu_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TPQ: tpq_in = TPQ_W'(csr_wdata);
            CSR_SIU: siu_in = csr_wdata[SIU_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpq_ff <= TPQ_RESET;
         siu_ff <= SIU_RESET;
      end else begin
         tpq_ff <= tpq_in;
         siu_ff <= siu_in;
      end
   end

   bbt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_entry_index     (req_entry_index),
      .req_start_tick      (req_start_tick),
      .req_sig_numerator   (req_sig_numerator),
      .req_sig_denominator (req_sig_denominator),
      .req_tick_in         (req_tick_in),
      .req_bar_in          (req_bar_in),
      .req_beat_in         (req_beat_in),
      .req_offset_in_beat  (req_offset_in_beat),
      .q_valid             (q_valid),
      .q_cmd               (q_cmd),
      .q_pop               (q_pop)
   );

   bbt_back #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .tpq            (tpq_ff),
      .siu            (siu_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tick_out   (rsp_tick_out),
      .rsp_bar_out    (rsp_bar_out),
      .rsp_beat_out   (rsp_beat_out),
      .rsp_offset_out (rsp_offset_out),
      .rsp_status     (rsp_status)
   );

endmodule
